// ===== rtl/cv_envelope_slew_generator_defines.svh =====
// ---------------------------------------------------------------------------
// cv_envelope_slew_generator_defines
// Assertion macros for the envelope and slew generator RTL.
// ---------------------------------------------------------------------------
`ifndef CV_ENVELOPE_SLEW_GENERATOR_DEFINES_SVH
`define CV_ENVELOPE_SLEW_GENERATOR_DEFINES_SVH

// same-cycle implication, clocked on clock, off during reset
`define CVESG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define CVESG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/cvesg_pkg.sv =====
// ---------------------------------------------------------------------------
// cvesg_pkg
// Shared widths, note constants, command, phase and register codes, and the full-scale helper.
// ---------------------------------------------------------------------------
package cvesg_pkg;

   localparam int LEVEL_W   = 16;
   localparam int ELAPSED_W = 17;
   localparam int LEN_W     = 17;
   localparam int PROD_W    = 33;
   localparam int DEPTH_W   = 5;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam logic [LEVEL_W-1:0] NOTE_LOW  = 16'd24;
   localparam logic [LEVEL_W-1:0] NOTE_HIGH = 16'd72;
   localparam logic [LEVEL_W-1:0] NOTE_STEP = 16'(4000 / 48);

   // command codes
   localparam logic [2:0] OP_TICK    = 3'd0;
   localparam logic [2:0] OP_TRIGGER = 3'd1;
   localparam logic [2:0] OP_GATE    = 3'd2;
   localparam logic [2:0] OP_TGATE   = 3'd3;
   localparam logic [2:0] OP_SLEW    = 3'd4;
   localparam logic [2:0] OP_MIDI    = 3'd5;
   localparam logic [2:0] OP_AR      = 3'd6;

   // phase codes
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_TRIGGER = 3'd1;
   localparam logic [2:0] PH_TGATE   = 3'd2;
   localparam logic [2:0] PH_GLIDE   = 3'd3;
   localparam logic [2:0] PH_ATTACK  = 3'd4;
   localparam logic [2:0] PH_RELEASE = 3'd5;

   // register indexes
   localparam logic REG_BIT_DEPTH = 1'b0;
   localparam logic REG_TRIG_LEN  = 1'b1;

   function automatic logic [LEVEL_W-1:0] full_scale(input logic [DEPTH_W-1:0] depth);
      logic [LEVEL_W:0] ones;
      begin
         ones = 17'd0;
         if (depth >= 5'd16) begin
            ones = 17'h0FFFF;
         end else begin
            ones = (17'd1 << depth) - 17'd1;
         end
         full_scale = ones[LEVEL_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/cvesg_csr.sv =====
// ---------------------------------------------------------------------------
// cvesg_csr
// Configuration registers behind the APB-style port.
// ---------------------------------------------------------------------------
module cvesg_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [cvesg_pkg::CSR_AW-1:0]  paddr,
   input  logic [cvesg_pkg::CSR_DW-1:0]  pwdata,
   output logic [cvesg_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready,
   output logic [cvesg_pkg::DEPTH_W-1:0] bit_depth,
   output logic [cvesg_pkg::LEVEL_W-1:0] trig_len
);
   import cvesg_pkg::*;

   logic [DEPTH_W-1:0] bit_depth_ff, bit_depth_in;
   logic [LEVEL_W-1:0] trig_len_ff, trig_len_in;
   logic               wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      bit_depth_in = bit_depth_ff;
      trig_len_in  = trig_len_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_BIT_DEPTH: bit_depth_in = pwdata[DEPTH_W-1:0];
            REG_TRIG_LEN:  trig_len_in  = pwdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_depth_ff <= 5'd12;
         trig_len_ff  <= 16'd10;
      end else begin
         bit_depth_ff <= bit_depth_in;
         trig_len_ff  <= trig_len_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_BIT_DEPTH: prdata = CSR_DW'(bit_depth_ff);
         REG_TRIG_LEN:  prdata = CSR_DW'(trig_len_ff);
         default:       prdata = '0;
      endcase
   end

   assign bit_depth = bit_depth_ff;
   assign trig_len  = trig_len_ff;

endmodule

// ===== rtl/cvesg_div.sv =====
// ---------------------------------------------------------------------------
// cvesg_div
// Restoring divider, one quotient bit per cycle, 16-bit quotient.
// ---------------------------------------------------------------------------
module cvesg_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [cvesg_pkg::PROD_W-1:0]  num,
   input  logic [cvesg_pkg::LEN_W-1:0]   den,
   output logic                        done,
   output logic [cvesg_pkg::LEVEL_W-1:0] quot
);
   import cvesg_pkg::*;

   // num must be below den * 2^16 so the upper part starts below den
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [3:0]         count_ff, count_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic [LEVEL_W-1:0] low_ff, low_in;
   logic [LEN_W-1:0]   den_ff, den_in;
   logic [LEN_W:0]     trial;

   assign trial = {rem_ff, low_ff[LEVEL_W-1]} - {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = num[PROD_W-1:LEVEL_W];
         low_in   = num[LEVEL_W-1:0];
         den_in   = den;
      end else if (busy_ff) begin
         if (!trial[LEN_W]) begin
            rem_in = trial[LEN_W-1:0];
            low_in = {low_ff[LEVEL_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[LEN_W-2:0], low_ff[LEVEL_W-1]};
            low_in = {low_ff[LEVEL_W-2:0], 1'b0};
         end
         count_in = count_ff + 4'd1;
         if (count_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = low_ff;

endmodule

// ===== rtl/cv_envelope_slew_generator.sv =====
// ---------------------------------------------------------------------------
// cv_envelope_slew_generator
// Control-voltage source: triggers, gates, glides and attack-release envelopes.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one command or 1 ms tick item; operation rides in req_tuser.
//   rsp_* returns exactly one item per request: the level after that item in
//   rsp_tdata and the phase in rsp_tuser.
//   csr_* is an APB-style port holding bit_depth (0x0) and trigger_length (0x4).
// Flow:
//   A command or a plain tick passes through the EXEC and FINISH states before
//   rsp_tvalid rises. A tick inside a glide, attack or release that has not
//   ended also passes MUL, LOAD and DIV: one multiply, then 16 steps in the
//   shared restoring divider. req_tready is high only while idle.
// Reset:
//   Synchronous, active high. Clears level, phase and all timers; bit_depth
//   returns to 12 and trigger_length to 10.
// Backpressure:
//   A finished item sits in the output register while rsp_tready is low; the
//   next request is still taken and computed, and waits before the output.
// ---------------------------------------------------------------------------
module cv_envelope_slew_generator (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // value[15:0], rise_time[31:16], fall_time[47:32],
                                   // gate_length[63:48]
   input  logic [2:0]  req_tuser,  // operation[2:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // level[15:0]
   output logic [2:0]  rsp_tuser,  // phase[2:0]
   // configuration port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [cvesg_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [cvesg_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [cvesg_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import cvesg_pkg::*;

   `include "cv_envelope_slew_generator_defines.svh"

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_LOAD,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   // latched request
   logic [2:0]         op_ff, op_in;
   logic [LEVEL_W-1:0] val_ff, val_in;
   logic [LEVEL_W-1:0] rise_ff, rise_in;
   logic [LEVEL_W-1:0] fall_ff, fall_in;
   logic [LEVEL_W-1:0] glen_ff, glen_in;

   // architectural state
   logic [2:0]           mode_ff, mode_in;
   logic [LEVEL_W-1:0]   out_ff, out_in;
   logic [LEVEL_W-1:0]   start_ff, start_in;
   logic [LEVEL_W-1:0]   goal_ff, goal_in;
   logic [LEVEL_W-1:0]   up_ff, up_in;
   logic [LEVEL_W-1:0]   down_ff, down_in;
   logic [LEVEL_W-1:0]   hold_ff, hold_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;

   // interpolation datapath
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               neg_ff, neg_in;
   logic [LEVEL_W-1:0] mag_ff, mag_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic [2:0]         rsp_phase_ff, rsp_phase_in;

   logic [DEPTH_W-1:0]   bit_depth;
   logic [LEVEL_W-1:0]   trig_len;
   logic [LEVEL_W-1:0]   fs;
   logic [ELAPSED_W-1:0] elapsed_inc;
   logic [LEN_W-1:0]     tick_len;
   logic [LEVEL_W-1:0]   note_clamp;
   logic [LEVEL_W-1:0]   note_goal;
   logic [LEVEL_W-1:0]   slew_goal;
   logic                 div_start;
   logic [PROD_W-1:0]    div_num;
   logic                 div_done;
   logic [LEVEL_W-1:0]   div_quot;

   cvesg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .bit_depth (bit_depth),
      .trig_len  (trig_len)
   );

   // numerator gets len-1 added on the negative side to round toward minus infinity
   assign div_num = prod_ff + (neg_ff ? PROD_W'(len_ff - 17'd1) : '0);

   cvesg_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (len_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign fs          = full_scale(bit_depth);
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 17'd1;
   assign note_clamp  = (val_ff < NOTE_LOW) ? NOTE_LOW :
                        ((val_ff > NOTE_HIGH) ? NOTE_HIGH : val_ff);
   assign note_goal   = (note_clamp - NOTE_LOW) * NOTE_STEP;
   assign slew_goal   = (val_ff > fs) ? fs : val_ff;

   // glide length for the current mode, time + 1
   always_comb begin
      case (mode_ff)
         PH_GLIDE:   tick_len = (goal_ff > start_ff) ? {1'b0, up_ff} + 17'd1
                                                     : {1'b0, down_ff} + 17'd1;
         PH_ATTACK:  tick_len = {1'b0, up_ff} + 17'd1;
         PH_RELEASE: tick_len = {1'b0, down_ff} + 17'd1;
         default:    tick_len = {1'b0, down_ff} + 17'd1;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      val_in     = val_ff;
      rise_in    = rise_ff;
      fall_in    = fall_ff;
      glen_in    = glen_ff;
      mode_in    = mode_ff;
      out_in     = out_ff;
      start_in   = start_ff;
      goal_in    = goal_ff;
      up_in      = up_ff;
      down_in    = down_ff;
      hold_in    = hold_ff;
      elapsed_in = elapsed_ff;
      len_in     = len_ff;
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      prod_in    = prod_ff;
      div_start  = 1'b0;
      // drop the output item once taken
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_level_in = rsp_level_ff;
      rsp_phase_in = rsp_phase_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               val_in   = req_tdata[15:0];
               rise_in  = req_tdata[31:16];
               fall_in  = req_tdata[47:32];
               glen_in  = req_tdata[63:48];
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_FINISH;
            case (op_ff)
               OP_TICK: begin
                  elapsed_in = elapsed_inc;
                  case (mode_ff)
                     PH_TRIGGER: begin
                        if (elapsed_inc > {1'b0, trig_len}) begin
                           out_in  = '0;
                           mode_in = PH_IDLE;
                        end
                     end
                     PH_TGATE: begin
                        if (elapsed_inc > {1'b0, hold_ff}) begin
                           out_in  = '0;
                           mode_in = PH_IDLE;
                        end
                     end
                     PH_GLIDE, PH_ATTACK, PH_RELEASE: begin
                        if (elapsed_inc > tick_len) begin
                           // glide over: land on the end point
                           if (mode_ff == PH_GLIDE) begin
                              out_in  = goal_ff;
                              mode_in = PH_IDLE;
                           end else if (mode_ff == PH_ATTACK) begin
                              out_in     = fs;
                              start_in   = fs;
                              goal_in    = '0;
                              elapsed_in = '0;
                              mode_in    = PH_RELEASE;
                           end else begin
                              out_in  = '0;
                              mode_in = PH_IDLE;
                           end
                        end else begin
                           // interpolate through the shared divider
                           len_in   = tick_len;
                           neg_in   = goal_ff < start_ff;
                           mag_in   = (goal_ff < start_ff) ? start_ff - goal_ff
                                                           : goal_ff - start_ff;
                           state_in = ST_MUL;
                        end
                     end
                     default: ;
                  endcase
               end
               OP_TRIGGER: begin
                  out_in     = fs;
                  elapsed_in = '0;
                  mode_in    = PH_TRIGGER;
               end
               OP_GATE: begin
                  out_in  = (val_ff != '0) ? fs : '0;
                  mode_in = PH_IDLE;
               end
               OP_TGATE: begin
                  out_in     = (val_ff != '0) ? fs : '0;
                  hold_in    = glen_ff;
                  elapsed_in = '0;
                  mode_in    = PH_TGATE;
               end
               OP_SLEW: begin
                  start_in   = out_ff;
                  goal_in    = slew_goal;
                  up_in      = rise_ff;
                  down_in    = fall_ff;
                  elapsed_in = '0;
                  mode_in    = PH_GLIDE;
               end
               OP_MIDI: begin
                  start_in   = out_ff;
                  goal_in    = note_goal;
                  up_in      = '0;
                  down_in    = '0;
                  elapsed_in = '0;
                  mode_in    = PH_GLIDE;
               end
               OP_AR: begin
                  start_in   = '0;
                  out_in     = '0;
                  goal_in    = fs;
                  up_in      = rise_ff;
                  down_in    = fall_ff;
                  elapsed_in = '0;
                  mode_in    = PH_ATTACK;
               end
               default: ;
            endcase
         end

         ST_MUL: begin
            prod_in  = PROD_W'(mag_ff) * PROD_W'(elapsed_ff);
            state_in = ST_LOAD;
         end

         ST_LOAD: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end

         ST_DIV: begin
            if (div_done) begin
               out_in   = neg_ff ? start_ff - div_quot : start_ff + div_quot;
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = out_ff;
               rsp_phase_in = mode_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= PH_IDLE;
         out_ff       <= '0;
         start_ff     <= '0;
         goal_ff      <= '0;
         up_ff        <= '0;
         down_ff      <= '0;
         hold_ff      <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         out_ff       <= out_in;
         start_ff     <= start_in;
         goal_ff      <= goal_in;
         up_ff        <= up_in;
         down_ff      <= down_in;
         hold_ff      <= hold_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      val_ff       <= val_in;
      rise_ff      <= rise_in;
      fall_ff      <= fall_in;
      glen_ff      <= glen_in;
      len_ff       <= len_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      prod_ff      <= prod_in;
      rsp_level_ff <= rsp_level_in;
      rsp_phase_ff <= rsp_phase_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_level_ff;
   assign rsp_tuser  = rsp_phase_ff;

   `CVESG_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready,
      "request taken while a previous item is in flight")
   `CVESG_ASSERT_NOW(a_div_done_in_div, div_done, state_ff == ST_DIV,
      "divider finished outside the divide step")
   `CVESG_ASSERT_NOW(a_rsp_from_finish, $rose(rsp_tvalid), $past(state_ff == ST_FINISH),
      "result item raised without a finished computation")

endmodule

// ===== bench/cv_envelope_slew_generator_checker.sv =====
// ---------------------------------------------------------------------------
// cv_envelope_slew_generator_checker
// Watches the request, result and configuration traffic of the envelope and
// slew generator, predicts level and phase for every accepted item and
// compares each returned item against the oldest prediction.
// ---------------------------------------------------------------------------
module cv_envelope_slew_generator_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [63:0]                   req_tdata,  // value, rise_time, fall_time, gate_length
   input  logic [2:0]                    req_tuser,  // operation
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [15:0]                   rsp_tdata,  // level
   input  logic [2:0]                    rsp_tuser,  // phase
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [cvesg_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [cvesg_pkg::CSR_DW-1:0]  csr_pwdata,
   input  logic                          csr_pready,
   output int                            mismatch_total,
   output int                            levels_outstanding
);
   import cvesg_pkg::*;

   localparam logic [15:0] NOTE_FLOOR     = 16'd24;
   localparam logic [15:0] NOTE_CEIL      = 16'd72;
   localparam logic [15:0] NOTE_CODE_STEP = 16'd83;
   localparam logic [16:0] TICKS_MAX      = 17'h1FFFF;

   typedef struct packed {
      logic [15:0] level;
      logic [2:0]  phase;
   } cv_result_type;

   cv_result_type predicted_levels[$];
   int            mismatches = 0;

   // configuration copy
   logic [4:0]  depth_q;
   logic [15:0] trig_len_q;

   // generator state copy
   logic [2:0]  ph;
   logic [15:0] lvl;
   logic [15:0] lvl_from;
   logic [15:0] lvl_to;
   logic [15:0] t_up;
   logic [15:0] t_down;
   logic [15:0] t_hold;
   logic [16:0] ticks;

   function automatic logic [15:0] ceiling_code(input logic [4:0] d);
      logic [16:0] ones;
      if (d > 5'd16) begin
         ones = 17'h0FFFF;
      end else begin
         ones = (17'd1 << d) - 17'd1;
      end
      return ones[15:0];
   endfunction

   // start + floor((to - from) * ticks / len), rounded toward minus infinity
   function automatic logic [15:0] glide_point(input logic [16:0] len);
      longint from_l, to_l, len_l, ticks_l, prod, q;
      from_l  = lvl_from;
      to_l    = lvl_to;
      len_l   = len;
      ticks_l = ticks;
      prod    = (to_l - from_l) * ticks_l;
      if (prod >= 0) begin
         q = prod / len_l;
      end else begin
         q = -((-prod + len_l - 1) / len_l);
      end
      return 16'(from_l + q);
   endfunction

   task automatic reset_model();
      depth_q    = 5'd12;
      trig_len_q = 16'd10;
      ph         = PH_IDLE;
      lvl        = '0;
      lvl_from   = '0;
      lvl_to     = '0;
      t_up       = '0;
      t_down     = '0;
      t_hold     = '0;
      ticks      = '0;
   endtask

   task automatic advance_tick();
      logic [16:0] len;
      if (ticks != TICKS_MAX) begin
         ticks = ticks + 17'd1;
      end
      case (ph)
         PH_TRIGGER: begin
            if (ticks > trig_len_q) begin
               lvl = '0;
               ph  = PH_IDLE;
            end
         end
         PH_TGATE: begin
            if (ticks > t_hold) begin
               lvl = '0;
               ph  = PH_IDLE;
            end
         end
         PH_GLIDE: begin
            len = {1'b0, (lvl_to > lvl_from) ? t_up : t_down} + 17'd1;
            if (ticks > len) begin
               lvl = lvl_to;
               ph  = PH_IDLE;
            end else begin
               lvl = glide_point(len);
            end
         end
         PH_ATTACK: begin
            len = {1'b0, t_up} + 17'd1;
            if (ticks > len) begin
               // attack done: jump to full scale and release toward zero
               lvl      = ceiling_code(depth_q);
               lvl_from = lvl;
               lvl_to   = '0;
               ticks    = '0;
               ph       = PH_RELEASE;
            end else begin
               lvl = glide_point(len);
            end
         end
         PH_RELEASE: begin
            len = {1'b0, t_down} + 17'd1;
            if (ticks > len) begin
               lvl = '0;
               ph  = PH_IDLE;
            end else begin
               lvl = glide_point(len);
            end
         end
         default: ;
      endcase
   endtask

   task automatic begin_glide(input logic [15:0] goal, input logic [15:0] up,
                              input logic [15:0] down);
      lvl_from = lvl;
      lvl_to   = goal;
      t_up     = up;
      t_down   = down;
      ticks    = '0;
      ph       = PH_GLIDE;
   endtask

   task automatic apply_item(input logic [2:0] op, input logic [15:0] val,
                             input logic [15:0] rise, input logic [15:0] fall,
                             input logic [15:0] glen);
      logic [15:0] top_code;
      logic [15:0] note;
      top_code = ceiling_code(depth_q);
      case (op)
         OP_TICK: begin
            advance_tick();
         end
         OP_TRIGGER: begin
            lvl   = top_code;
            ticks = '0;
            ph    = PH_TRIGGER;
         end
         OP_GATE: begin
            lvl = (val != 16'd0) ? top_code : 16'd0;
            ph  = PH_IDLE;
         end
         OP_TGATE: begin
            lvl    = (val != 16'd0) ? top_code : 16'd0;
            t_hold = glen;
            ticks  = '0;
            ph     = PH_TGATE;
         end
         OP_SLEW: begin
            begin_glide((val > top_code) ? top_code : val, rise, fall);
         end
         OP_MIDI: begin
            note = (val < NOTE_FLOOR) ? NOTE_FLOOR : ((val > NOTE_CEIL) ? NOTE_CEIL : val);
            begin_glide(16'((note - NOTE_FLOOR) * NOTE_CODE_STEP), 16'd0, 16'd0);
         end
         OP_AR: begin
            lvl_from = '0;
            lvl      = '0;
            lvl_to   = top_code;
            t_up     = rise;
            t_down   = fall;
            ticks    = '0;
            ph       = PH_ATTACK;
         end
         default: ;
      endcase
      predicted_levels.push_back('{lvl, ph});
   endtask

   task automatic note_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch, %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      cv_result_type want;
      if (reset) begin
         reset_model();
         predicted_levels.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_TRIG_LEN) begin
               trig_len_q = csr_pwdata[15:0];
            end else begin
               depth_q = csr_pwdata[4:0];
            end
         end
         // compare before predicting: no item comes back in the cycle it went in
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_levels.size() == 0) begin
               note_mismatch("result item with none pending, level", rsp_tdata, 0);
            end else begin
               want = predicted_levels.pop_front();
               if (rsp_tdata !== want.level) begin
                  note_mismatch("level", rsp_tdata, want.level);
               end
               if (rsp_tuser !== want.phase) begin
                  note_mismatch("phase", rsp_tuser, want.phase);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            apply_item(req_tuser, req_tdata[15:0], req_tdata[31:16], req_tdata[47:32],
                       req_tdata[63:48]);
         end
      end
      mismatch_total     <= mismatches;
      levels_outstanding <= predicted_levels.size();
   end

endmodule

// ===== bench/cv_envelope_slew_generator_tb.sv =====
// ---------------------------------------------------------------------------
// cv_envelope_slew_generator_tb
// Drives command and tick items into the envelope and slew generator under
// several bit depth and trigger length settings, with bursty requests and a
// randomly stalling receiver; the checker predicts and compares every item.
// ---------------------------------------------------------------------------
module cv_envelope_slew_generator_tb;
   import cvesg_pkg::*;

   localparam logic [2:0] OP_UNUSED       = 3'd7;
   localparam int         HOLD_OFF_CYCLES = 400;   // long receiver stall
   localparam int         WATCHDOG_LIMIT  = 3000;  // cycles with no handshake at all
   localparam int         DRAIN_CYCLES    = 30;    // margin after the last result
   localparam int         ITEMS_PER_PHASE = 62;
   localparam int         PHASE_COUNT     = 7;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [63:0]       req_tdata   = '0;
   logic [2:0]        req_tuser   = OP_TICK;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [15:0]       rsp_tdata;
   logic [2:0]        rsp_tuser;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   int mismatch_total;
   int levels_outstanding;
   int items_sent    = 0;
   int burst_left    = 0;
   bit hold_off_req  = 1'b0;
   bit hold_off_done = 1'b0;

   always #4 clock = ~clock;

   cv_envelope_slew_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   cv_envelope_slew_generator_checker level_check (
      .clock              (clock),
      .reset              (reset),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_tdata          (req_tdata),
      .req_tuser          (req_tuser),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .rsp_tuser          (rsp_tuser),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_pready         (csr_pready),
      .mismatch_total     (mismatch_total),
      .levels_outstanding (levels_outstanding)
   );

   // Offer one item and hold it until the block takes it. Valid is left high
   // so a following item in the same burst goes out without a bubble.
   task automatic send_item(input logic [2:0] op, input logic [15:0] v, input logic [15:0] r,
                            input logic [15:0] f, input logic [15:0] g);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {g, f, r, v};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Send an item, then close the burst with a random gap when it runs out.
   // Some bursts end with no gap at all, giving long stretches of back-to-back
   // requests.
   task automatic issue(input logic [2:0] op, input logic [15:0] v, input logic [15:0] r,
                        input logic [15:0] f, input logic [15:0] g);
      send_item(op, v, r, f, g);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // APB write: setup then access. Select is left high so back-to-back writes
   // go straight from access to the next setup; configure drops it.
   task automatic csr_write(input logic idx, input logic [CSR_DW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // Drain every outstanding item, then rewrite both registers while idle.
   task automatic configure(input logic [4:0] depth, input logic [15:0] trig_len);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (levels_outstanding != 0);
      csr_write(REG_BIT_DEPTH, {27'd0, depth});
      csr_write(REG_TRIG_LEN, {16'd0, trig_len});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Mostly short durations so glides and envelopes run to completion inside
   // a tick run; now and then any 16-bit value.
   function automatic logic [15:0] pick_time();
      if ($urandom_range(0, 7) == 0) begin
         return 16'($urandom);
      end
      return 16'($urandom_range(0, 6));
   endfunction

   // One command with random content followed by a run of ticks; the fields
   // of a tick are ignored by the block, so fill them with noise.
   task automatic run_sequence();
      logic [2:0]  op;
      logic [15:0] v;
      int          tick_run;
      op = 3'($urandom_range(0, 7));
      case (op)
         OP_MIDI: begin
            v = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 90)) : 16'($urandom);
         end
         OP_GATE, OP_TGATE: begin
            v = ($urandom_range(0, 1) != 0) ? 16'd0 : 16'($urandom);
         end
         default: begin
            v = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
         end
      endcase
      issue(op, v, pick_time(), pick_time(), pick_time());
      tick_run = $urandom_range(0, 14);
      repeat (tick_run) begin
         issue(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end
   endtask

   // Receiver: runs of always-ready, coin-flip and mostly-stalled cycles, plus
   // one long hold-off on request so the block fills up and drops req_tready.
   initial begin : receiver
      int span;
      int style;
      forever begin
         if (hold_off_req && !hold_off_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_done = 1'b1;
         end else begin
            span  = $urandom_range(1, 30);
            style = $urandom_range(0, 2);
            repeat (span) begin
               case (style)
                  0:       rsp_tready <= 1'b1;
                  1:       rsp_tready <= 1'($urandom_range(0, 1));
                  default: rsp_tready <= ($urandom_range(0, 3) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // Watchdog: end the run if no handshake of any kind happens for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      int          phase_mark;
      logic [4:0]  depth_sel;
      logic [15:0] trig_sel;

      // hold reset, then release it once
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at full 16-bit depth with a one-tick trigger.
      configure(5'd16, 16'd1);
      issue(OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);   // idle tick
      issue(OP_TRIGGER, 16'd0, 16'd0, 16'd0, 16'd0);
      issue(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0);               // trigger still high
      issue(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0);               // trigger expires
      issue(OP_GATE, 16'd0, 16'd0, 16'd0, 16'd0);               // gate low
      issue(OP_GATE, 16'hFFFF, 16'd0, 16'd0, 16'd0);            // gate high
      issue(OP_TGATE, 16'd1, 16'd0, 16'd0, 16'd1);              // one-tick timed gate
      issue(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0);
      issue(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0);               // gate times out
      issue(OP_SLEW, 16'hFFFF, 16'd2, 16'd0, 16'd0);            // upward glide
      issue(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0);
      issue(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0);
      issue(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0);
      issue(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0);               // glide lands on goal
      issue(OP_SLEW, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF);         // downward glide uses fall
      issue(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0);
      issue(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0);
      issue(OP_MIDI, 16'd0, 16'd0, 16'd0, 16'd0);               // note clamped up to the floor
      issue(OP_MIDI, 16'hFFFF, 16'd0, 16'd0, 16'd0);            // note clamped down to the top
      issue(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0);
      issue(OP_AR, 16'd0, 16'd0, 16'd0, 16'd0);                 // shortest envelope
      issue(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0);
      issue(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0);               // attack done, release starts
      issue(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0);
      issue(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF); // unused code changes nothing

      // Random part: one phase per register setting, the extremes among them.
      // Each configure also pauses the requests until every result is back.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0:       begin depth_sel = 5'd12; trig_sel = 16'd10;    end
            1:       begin depth_sel = 5'd0;  trig_sel = 16'd0;     end
            2:       begin depth_sel = 5'd1;  trig_sel = 16'hFFFF;  end
            3:       begin depth_sel = 5'd31; trig_sel = 16'd3;     end
            4:       begin depth_sel = 5'd16; trig_sel = 16'd0;     end
            5:       begin depth_sel = 5'd8;  trig_sel = 16'd5;     end
            default: begin
               depth_sel = 5'($urandom_range(0, 31));
               trig_sel  = 16'($urandom_range(0, 20));
            end
         endcase
         configure(depth_sel, trig_sel);
         // ask the receiver for its long hold-off while requests keep coming
         if (p == 2) begin
            hold_off_req = 1'b1;
         end
         phase_mark = items_sent;
         while (items_sent - phase_mark < ITEMS_PER_PHASE) begin
            run_sequence();
         end
      end

      // drop valid, wait for the last result, then let the pipeline settle
      req_tvalid <= 1'b0;
      do @(posedge clock); while (levels_outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_total == 0 && levels_outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
